>>> rtl/tcn_pkg.sv
// Shared types and constants for the template correlation block.
package tcn_pkg;

  localparam int unsigned MaxImageRows = 256;
  localparam int unsigned MaxImageCols = 256;
  localparam int unsigned MaxMaskRows  = 16;
  localparam int unsigned MaxMaskCols  = 16;
  localparam int unsigned DivStages    = 8;

  typedef enum logic [1:0] {
    REQ_MASK  = 2'd0,
    REQ_IMAGE = 2'd1,
    REQ_FETCH = 2'd2,
    REQ_RSVD  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_MASK_ROWS  = 2'd0,
    CFG_MASK_COLS  = 2'd1,
    CFG_IMAGE_ROWS = 2'd2,
    CFG_IMAGE_COLS = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPUTE,
    ST_DRAIN,
    ST_FETCH,
    ST_DELIVER
  } state_e;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] den;
    logic [7:0]  quo;
    logic        last;
  } div_word_t;

endpackage

>>> rtl/tcn_div_cell.sv
// One restoring division cell that resolves a single quotient bit.
module tcn_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tcn_pkg::div_word_t word_i,
  output logic              valid_o,
  output tcn_pkg::div_word_t word_o
);

  logic              valid_q;
  tcn_pkg::div_word_t word_q, word_d;
  logic              ge;

  always_comb begin
    ge          = word_i.rem >= word_i.den;
    word_d.rem  = ge ? (word_i.rem - word_i.den) : word_i.rem;
    word_d.den  = word_i.den >> 1;
    word_d.quo  = {word_i.quo[6:0], ge};
    word_d.last = word_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> rtl/tcn_div_chain.sv
// Row of division cells that scales a sum against the peak, one bit per cell.
module tcn_div_chain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tcn_pkg::div_word_t word_i,
  output logic              valid_o,
  output tcn_pkg::div_word_t word_o
);

  logic              v [0:tcn_pkg::DivStages];
  tcn_pkg::div_word_t w [0:tcn_pkg::DivStages];

  assign v[0] = valid_i;
  assign w[0] = word_i;

  for (genvar k = 0; k < tcn_pkg::DivStages; k++) begin : g_cell
    tcn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .word_i  (w[k]),
      .valid_o (v[k+1]),
      .word_o  (w[k+1])
    );
  end

  assign valid_o = v[tcn_pkg::DivStages];
  assign word_o  = w[tcn_pkg::DivStages];

endmodule

>>> rtl/template_correlation_normalize.sv
// Top level of the template correlation and normalisation block.
// Mask and image loads carry one pixel each. The final image load starts the
// correlation pass, which feeds one mask tap a cycle through the shared
// multiply-accumulate and then drains; inputs are stalled meanwhile. A fetch
// passes through one sum memory read, eight division cells, the result
// register and the output register, and the next transaction is taken once
// the result is handed on.
module template_correlation_normalize (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] pixel_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_pixel_o,
  output logic       last_pixel_o
);

  tcn_pkg::state_e state_q, state_d;

  logic [4:0]  mrows_q, mcols_q;
  logic [8:0]  irows_q, icols_q;
  logic [4:0]  mr, mc;
  logic [8:0]  ir, ic;
  logic [8:0]  mtot;
  logic [16:0] itot;

  logic [7:0]  mload_q;
  logic [15:0] iload_q, oidx_q;
  logic        ready_q;
  logic [23:0] peak_q;

  logic [7:0]  mask_mem  [0:tcn_pkg::MaxMaskRows*tcn_pkg::MaxMaskCols-1];
  logic [7:0]  image_mem [0:tcn_pkg::MaxImageRows*tcn_pkg::MaxImageCols-1];
  logic [23:0] sum_mem   [0:tcn_pkg::MaxImageRows*tcn_pkg::MaxImageCols-1];

  logic [7:0]  ci_q, cj_q, midx_q;
  logic [3:0]  cr_q, cc_q;
  logic [15:0] pidx_q;

  logic        v1_q, inb1_q, first1_q, last1_q;
  logic [15:0] pidx1_q;
  logic [7:0]  mdat_q, idat_q;
  logic [15:0] prod;
  logic        v2_q, last2_q;
  logic [15:0] pidx2_q;
  logic [23:0] acc_q, acc_d;

  logic        rd_v_q, rd_last_q;
  logic [23:0] rd_sum_q;
  logic        div_v;
  tcn_pkg::div_word_t div_in, div_out;
  logic [7:0]  res_pix_q;
  logic        res_last_q;

  logic        out_valid_q, out_last_q;
  logic [7:0]  out_pix_q;

  logic        in_acc, is_mask, is_image, is_fetch;
  logic [7:0]  mwidx, mnext;
  logic [15:0] iwidx, inext, fidx, fnext;
  logic        img_final, fetch_last;
  logic        issue, tap_last, pix_last, pass_end;
  logic [8:0]  ty, tx;
  logic [17:0] trow;
  logic [15:0] taddr;
  logic        tinb;
  logic        deliver;

  always_comb begin
    mr = (mrows_q == 5'd0) ? 5'd1 : (mrows_q > 5'(tcn_pkg::MaxMaskRows)) ?
         5'(tcn_pkg::MaxMaskRows) : mrows_q;
    mc = (mcols_q == 5'd0) ? 5'd1 : (mcols_q > 5'(tcn_pkg::MaxMaskCols)) ?
         5'(tcn_pkg::MaxMaskCols) : mcols_q;
    ir = (irows_q == 9'd0) ? 9'd1 : (irows_q > 9'(tcn_pkg::MaxImageRows)) ?
         9'(tcn_pkg::MaxImageRows) : irows_q;
    ic = (icols_q == 9'd0) ? 9'd1 : (icols_q > 9'(tcn_pkg::MaxImageCols)) ?
         9'(tcn_pkg::MaxImageCols) : icols_q;
    mtot = 9'(10'(mr) * 10'(mc));
    itot = 17'(18'(ir) * 18'(ic));
  end

  always_comb begin
    in_acc   = in_valid_i && !in_stall_o;
    is_mask  = in_acc && (req_type_i == tcn_pkg::REQ_MASK);
    is_image = in_acc && (req_type_i == tcn_pkg::REQ_IMAGE);
    is_fetch = in_acc && (req_type_i == tcn_pkg::REQ_FETCH);

    mwidx = ({1'b0, mload_q} >= mtot) ? 8'd0 : mload_q;
    mnext = ({1'b0, mwidx} + 9'd1 >= mtot) ? 8'd0 : mwidx + 8'd1;
    iwidx = ({1'b0, iload_q} >= itot) ? 16'd0 : iload_q;
    img_final = ({1'b0, iwidx} + 17'd1 >= itot);
    inext = img_final ? 16'd0 : iwidx + 16'd1;
    fidx  = ({1'b0, oidx_q} >= itot) ? 16'd0 : oidx_q;
    fetch_last = ({1'b0, fidx} == itot - 17'd1);
    fnext = fetch_last ? 16'd0 : fidx + 16'd1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcn_pkg::ST_IDLE: begin
        if (is_image && img_final) begin
          state_d = tcn_pkg::ST_COMPUTE;
        end else if (is_fetch && ready_q) begin
          state_d = tcn_pkg::ST_FETCH;
        end
      end
      tcn_pkg::ST_COMPUTE: begin
        if (pass_end) begin
          state_d = tcn_pkg::ST_DRAIN;
        end
      end
      tcn_pkg::ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = tcn_pkg::ST_IDLE;
        end
      end
      tcn_pkg::ST_FETCH: begin
        if (div_v) begin
          state_d = tcn_pkg::ST_DELIVER;
        end
      end
      tcn_pkg::ST_DELIVER: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = tcn_pkg::ST_IDLE;
        end
      end
      default: state_d = tcn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != tcn_pkg::ST_IDLE);
    issue      = (state_q == tcn_pkg::ST_COMPUTE);
    deliver    = (state_q == tcn_pkg::ST_DELIVER) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    tap_last = ({1'b0, cr_q} == mr - 5'd1) && ({1'b0, cc_q} == mc - 5'd1);
    pix_last = ({1'b0, ci_q} == ir - 9'd1) && ({1'b0, cj_q} == ic - 9'd1);
    pass_end = issue && tap_last && pix_last;
    ty    = {1'b0, ci_q} + {5'd0, cr_q};
    tx    = {1'b0, cj_q} + {5'd0, cc_q};
    tinb  = (ty < ir) && (tx < ic);
    trow  = ty * ic;
    taddr = trow[15:0] + {7'd0, tx};
    prod  = mdat_q * idat_q;
    acc_d = (first1_q ? 24'd0 : acc_q) +
            (inb1_q ? {8'd0, prod} : 24'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcn_pkg::ST_IDLE;
      mrows_q <= 5'd3;
      mcols_q <= 5'd3;
      irows_q <= 9'd256;
      icols_q <= 9'd256;
      mload_q <= '0;
      iload_q <= '0;
      oidx_q  <= '0;
      ready_q <= 1'b0;
      peak_q  <= '0;
      ci_q    <= '0;
      cj_q    <= '0;
      cr_q    <= '0;
      cc_q    <= '0;
      midx_q  <= '0;
      pidx_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      rd_v_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ready_q <= 1'b0;
        case (cfg_index_i)
          tcn_pkg::CFG_MASK_ROWS: begin
            mrows_q <= cfg_data_i[4:0];
            mload_q <= '0;
          end
          tcn_pkg::CFG_MASK_COLS: begin
            mcols_q <= cfg_data_i[4:0];
            mload_q <= '0;
          end
          tcn_pkg::CFG_IMAGE_ROWS: begin
            irows_q <= cfg_data_i;
            iload_q <= '0;
            oidx_q  <= '0;
          end
          default: begin
            icols_q <= cfg_data_i;
            iload_q <= '0;
            oidx_q  <= '0;
          end
        endcase
      end
      if (is_mask) begin
        mload_q <= mnext;
      end
      if (is_image) begin
        iload_q <= inext;
        ready_q <= 1'b0;
        if (img_final) begin
          oidx_q <= '0;
          peak_q <= '0;
          ci_q   <= '0;
          cj_q   <= '0;
          cr_q   <= '0;
          cc_q   <= '0;
          midx_q <= '0;
          pidx_q <= '0;
        end
      end
      if (is_fetch && ready_q) begin
        oidx_q <= fnext;
      end
      rd_v_q <= is_fetch && ready_q;
      if (issue) begin
        if (tap_last) begin
          cr_q   <= '0;
          cc_q   <= '0;
          midx_q <= '0;
          pidx_q <= pidx_q + 16'd1;
          if ({1'b0, cj_q} == ic - 9'd1) begin
            cj_q <= '0;
            ci_q <= ci_q + 8'd1;
          end else begin
            cj_q <= cj_q + 8'd1;
          end
        end else begin
          midx_q <= midx_q + 8'd1;
          if ({1'b0, cc_q} == mc - 5'd1) begin
            cc_q <= '0;
            cr_q <= cr_q + 4'd1;
          end else begin
            cc_q <= cc_q + 4'd1;
          end
        end
      end
      v1_q <= issue;
      v2_q <= v1_q;
      if (v2_q && last2_q && (acc_q > peak_q)) begin
        peak_q <= acc_q;
      end
      if ((state_q == tcn_pkg::ST_DRAIN) && !v1_q && !v2_q) begin
        ready_q <= 1'b1;
      end
      if (deliver) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_mask) begin
      mask_mem[mwidx] <= pixel_i;
    end
    if (is_image) begin
      image_mem[iwidx] <= pixel_i;
    end
    mdat_q   <= mask_mem[midx_q];
    idat_q   <= image_mem[taddr];
    inb1_q   <= tinb;
    first1_q <= (cr_q == 4'd0) && (cc_q == 4'd0);
    last1_q  <= tap_last;
    pidx1_q  <= pidx_q;
    if (v1_q) begin
      acc_q <= acc_d;
    end
    last2_q <= last1_q;
    pidx2_q <= pidx1_q;
    if (v2_q && last2_q) begin
      sum_mem[pidx2_q] <= acc_q;
    end
    rd_sum_q  <= sum_mem[fidx];
    rd_last_q <= fetch_last;
    if (div_v) begin
      res_pix_q  <= (peak_q == 24'd0) ? 8'd0 : div_out.quo;
      res_last_q <= div_out.last;
    end
    if (deliver) begin
      out_pix_q  <= res_pix_q;
      out_last_q <= res_last_q;
    end
  end

  always_comb begin
    div_in.rem  = ({8'd0, rd_sum_q} << 8) - {8'd0, rd_sum_q};
    div_in.den  = {1'b0, peak_q, 7'd0};
    div_in.quo  = 8'd0;
    div_in.last = rd_last_q;
  end

  tcn_div_chain u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q),
    .word_i  (div_in),
    .valid_o (div_v),
    .word_o  (div_out)
  );

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = out_pix_q;
  assign last_pixel_o = out_last_q;

  a_no_accept_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcn_pkg::ST_COMPUTE || state_q == tcn_pkg::ST_DRAIN) |-> in_stall_o)
    else $error("A transaction was taken during the correlation pass.");

  a_div_only_in_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v |-> (state_q == tcn_pkg::ST_FETCH))
    else $error("Division result outside a fetch.");

  a_ready_after_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tcn_pkg::ST_DRAIN) && (state_d == tcn_pkg::ST_IDLE)) |=> ready_q)
    else $error("Sums not marked ready after the pass.");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcn_pkg::ST_IDLE) |-> (!v1_q && !v2_q && !div_v))
    else $error("Pipeline busy while idle.");

endmodule
